/* rtl/i2cws_pkg.sv */
// Shared types and constants for the I2C write serializer.
package i2cws_pkg;

  localparam int unsigned BITS_PER_BYTE = 8;
  localparam int unsigned BIT_CNT_W     = $clog2(BITS_PER_BYTE + 1);

  localparam logic [7:0] ADDR_RESET   = 8'h78;
  localparam logic [7:0] CTRL_COMMAND = 8'h00;
  localparam logic [7:0] CTRL_DATA    = 8'h40;

  // Step counter positions inside a phase
  localparam logic [1:0] STEP_BIT_LAST   = 2'd2;
  localparam logic [1:0] STEP_ACK_LAST   = 2'd3;
  localparam logic [1:0] STEP_START_LAST = 2'd3;
  localparam logic [1:0] STEP_STOP_LAST  = 2'd2;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    ACT_BEGIN_CMD  = 2'd0,
    ACT_BEGIN_DATA = 2'd1,
    ACT_PAYLOAD    = 2'd2,
    ACT_STOP       = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    JOB_BEGIN,
    JOB_BYTE,
    JOB_STOP
  } job_kind_e;

  typedef struct packed {
    job_kind_e  kind;
    logic [7:0] byte_a;
    logic [7:0] byte_b;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } q_push_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } q_head_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_START,
    BK_BYTE_A,
    BK_BYTE_B,
    BK_STOP
  } back_state_e;

endpackage

/* rtl/i2cws_in_if.sv */
// Input channel: one action word with its payload byte.
interface i2cws_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] payload;

  modport source (output valid, output action, output payload, input ready);
  modport sink   (input valid, input action, input payload, output ready);
endinterface

/* rtl/i2cws_out_if.sv */
// Output channel: one pin-write event word.
interface i2cws_out_if;
  logic valid;
  logic ready;
  logic scl;
  logic sda;
  logic last;

  modport source (output valid, output scl, output sda, output last, input ready);
  modport sink   (input valid, input scl, input sda, input last, output ready);
endinterface

/* rtl/i2cws_front.sv */
// Front end: address register, action decode and queue push.
module i2cws_front
  import i2cws_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  i2cws_in_if.sink     in_i,
  input  logic         cfg_we_i,
  input  logic [7:0]   cfg_data_i,
  input  logic         full_i,
  output q_push_t      push_o
);

  logic [7:0] dev_addr_q;
  job_t       job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q <= ADDR_RESET;
    end else if (cfg_we_i) begin
      dev_addr_q <= cfg_data_i;
    end
  end

  always_comb begin
    job.kind   = JOB_STOP;
    job.byte_a = in_i.payload;
    job.byte_b = CTRL_COMMAND;
    unique case (action_e'(in_i.action))
      ACT_BEGIN_CMD: begin
        job.kind   = JOB_BEGIN;
        job.byte_a = dev_addr_q;
        job.byte_b = CTRL_COMMAND;
      end
      ACT_BEGIN_DATA: begin
        job.kind   = JOB_BEGIN;
        job.byte_a = dev_addr_q;
        job.byte_b = CTRL_DATA;
      end
      ACT_PAYLOAD: begin
        job.kind = JOB_BYTE;
      end
      ACT_STOP: begin
        job.kind = JOB_STOP;
      end
    endcase
  end

  assign in_i.ready   = !full_i;
  assign push_o.valid = in_i.valid && !full_i;
  assign push_o.job   = job;

endmodule

/* rtl/i2cws_fifo.sv */
// Short job queue between front end and sequencer.
module i2cws_fifo
  import i2cws_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  q_push_t push_i,
  output logic    full_o,
  output q_head_t head_o,
  input  logic    pop_i
);

  job_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push, do_pop;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(p + 1'b1);
  endfunction

  assign full_o       = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.job   = mem_q[rd_ptr_q];
  assign do_push      = push_i.valid && !full_o;
  assign do_pop       = pop_i && head_o.valid;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.job;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= QCNT_W'(cnt_q + 1'b1);
      end else if (do_pop && !do_push) begin
        cnt_q <= QCNT_W'(cnt_q - 1'b1);
      end
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_o.valid)
    else $error("pop from empty queue");

  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("pointers disagree on empty queue");

endmodule

/* rtl/i2cws_back.sv */
// Back end: pin event sequencer with output word register.
module i2cws_back
  import i2cws_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  q_head_t     head_i,
  output logic        pop_o,
  i2cws_out_if.source out_o
);

  back_state_e          state_q, state_d;
  logic [1:0]           step_q;
  logic [BIT_CNT_W-1:0] bit_q;
  logic [7:0]           shift_q, byte_b_q;
  logic                 scl_q, sda_q;
  logic                 out_valid_q, out_last_q;

  logic ev_drive_scl, ev_level, ev_last, ev_phase_end, ev_bit_end;
  logic in_ack, advance, load;

  assign in_ack  = (bit_q == BIT_CNT_W'(BITS_PER_BYTE));
  assign advance = (state_q != BK_IDLE) && (!out_valid_q || out_o.ready);

  // Event decode for the current step
  always_comb begin
    ev_drive_scl = 1'b0;
    ev_level     = 1'b1;
    ev_last      = 1'b0;
    ev_phase_end = 1'b0;
    ev_bit_end   = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
      end
      BK_START: begin
        ev_drive_scl = step_q[0];
        ev_level     = (step_q == 2'd0) || (step_q == 2'd1);
        ev_phase_end = (step_q == STEP_START_LAST);
      end
      BK_BYTE_A, BK_BYTE_B: begin
        if (in_ack) begin
          ev_drive_scl = (step_q != 2'd1);
          ev_level     = (step_q == 2'd1) || (step_q == 2'd2);
          ev_phase_end = (step_q == STEP_ACK_LAST);
          ev_last      = ev_phase_end && (state_q == BK_BYTE_B);
        end else begin
          ev_drive_scl = (step_q != 2'd1);
          ev_level     = (step_q == 2'd1) ? shift_q[7] : (step_q == STEP_BIT_LAST);
          ev_bit_end   = (step_q == STEP_BIT_LAST);
        end
      end
      BK_STOP: begin
        ev_drive_scl = (step_q == 2'd1);
        ev_level     = (step_q != 2'd0);
        ev_phase_end = (step_q == STEP_STOP_LAST);
        ev_last      = ev_phase_end;
      end
      default: begin
      end
    endcase
  end

  assign load  = ((state_q == BK_IDLE) || (advance && ev_last)) && head_i.valid;
  assign pop_o = load;

  // Next state
  always_comb begin
    state_d = state_q;
    if (load) begin
      unique case (head_i.job.kind)
        JOB_BEGIN: state_d = BK_START;
        JOB_BYTE:  state_d = BK_BYTE_B;
        JOB_STOP:  state_d = BK_STOP;
        default:   state_d = BK_IDLE;
      endcase
    end else if (advance) begin
      if (ev_last) begin
        state_d = BK_IDLE;
      end else if (ev_phase_end && state_q == BK_START) begin
        state_d = BK_BYTE_A;
      end else if (ev_phase_end && state_q == BK_BYTE_A) begin
        state_d = BK_BYTE_B;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      step_q      <= '0;
      bit_q       <= '0;
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (advance) begin
        out_valid_q <= 1'b1;
        out_last_q  <= ev_last;
        if (ev_drive_scl) begin
          scl_q <= ev_level;
        end else begin
          sda_q <= ev_level;
        end
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (load || (advance && ev_phase_end)) begin
        step_q <= '0;
        bit_q  <= '0;
      end else if (advance && ev_bit_end) begin
        step_q <= '0;
        bit_q  <= BIT_CNT_W'(bit_q + 1'b1);
      end else if (advance) begin
        step_q <= 2'(step_q + 2'd1);
      end
    end
  end

  // Byte shifter: payload needs no reset
  always_ff @(posedge clk_i) begin
    if (load) begin
      shift_q  <= head_i.job.byte_a;
      byte_b_q <= head_i.job.byte_b;
    end else if (advance && ev_phase_end && state_q == BK_BYTE_A) begin
      shift_q <= byte_b_q;
    end else if (advance && ev_bit_end) begin
      shift_q <= {shift_q[6:0], 1'b0};
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.scl   = scl_q;
  assign out_o.sda   = sda_q;
  assign out_o.last  = out_last_q;

  a_one_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> !((scl_q != $past(scl_q)) && (sda_q != $past(sda_q))))
    else $error("event moved both lines");

  a_bit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_BYTE_A || state_q == BK_BYTE_B) |->
      (bit_q <= BIT_CNT_W'(BITS_PER_BYTE)))
    else $error("bit count out of range");

  a_bit_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == BK_BYTE_A || state_q == BK_BYTE_B) && !in_ack) |-> (step_q != 2'd3))
    else $error("data bit step out of range");

  a_stop_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && state_q == BK_STOP && ev_last) |=> (scl_q && sda_q && out_last_q))
    else $error("stop did not release both lines");

endmodule

/* rtl/display_i2c_write_serializer.sv */
// Top level of the display I2C write serializer.
//
//   channel  dir  handshake            word
//   in_i     in   valid/ready          action[1:0], payload[7:0]
//   out_o    out  valid/ready          scl, sda, last
//   cfg      in   cfg_we_i (no ready)  cfg_data_i[7:0] -> device address
//
// A begin action makes 60 output words, a payload action 28, a stop 3.
// The sequencer emits one word per cycle while out_o takes them; the only
// gap comes when it picks up a job after running empty.
// in_i is taken whenever the two-entry job queue has room, so input and
// output stall independently. Reset releases both lines (scl = sda = 1)
// and loads device address 0x78.
module display_i2c_write_serializer
  import i2cws_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  i2cws_in_if.sink    in_i,
  i2cws_out_if.source out_o,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_data_i
);

  q_push_t push;
  q_head_t head;
  logic    q_full;
  logic    pop;

  // Decode actions into jobs and hold the address register
  i2cws_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .full_i     (q_full),
    .push_o     (push)
  );

  // Buffer jobs so the front keeps accepting while the sequencer runs
  i2cws_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (q_full),
    .head_o (head),
    .pop_i  (pop)
  );

  // Walk each job's pin events and hold the line levels across jobs
  i2cws_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .out_o  (out_o)
  );

endmodule

/* tb/sv/display_i2c_write_serializer_tb.sv */
// Testbench for the display I2C write serializer: random traffic checked against a line predictor.
module display_i2c_write_serializer_tb
  import i2cws_pkg::*;
;

  // Allow 60 words per action, each held by the longest stall, plus the sender gaps.
  // That is far below this limit.
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned RANDOM_ITEMS = 100;

  // Predict the pin-write words of each accepted action and hold them until checked.
  class pin_word_board;
    typedef struct packed {
      logic scl;
      logic sda;
      logic last;
    } pin_word_t;

    pin_word_t   expected_words[$];
    logic [7:0]  dev_addr;
    logic        clk_line;
    logic        dat_line;
    int unsigned mismatches;
    int unsigned words_checked;
    int unsigned actions_noted;

    function new();
      dev_addr      = ADDR_RESET;
      clk_line      = 1'b1;
      dat_line      = 1'b1;
      mismatches    = 0;
      words_checked = 0;
      actions_noted = 0;
    endfunction

    function void set_address(logic [7:0] addr);
      dev_addr = addr;
    endfunction

    function int unsigned pending();
      return expected_words.size();
    endfunction

    function void put_word();
      pin_word_t w;
      w.scl  = clk_line;
      w.sda  = dat_line;
      w.last = 1'b0;
      expected_words.push_back(w);
    endfunction

    function void set_scl(logic v);
      clk_line = v;
      put_word();
    endfunction

    function void set_sda(logic v);
      dat_line = v;
      put_word();
    endfunction

    // Eight bits MSB first, then an acknowledge slot with SDA released.
    function void shift_byte(logic [7:0] data);
      for (int i = 7; i >= 0; i--) begin
        set_scl(1'b0);
        set_sda(data[i]);
        set_scl(1'b1);
      end
      set_scl(1'b0);
      set_sda(1'b1);
      set_scl(1'b1);
      set_scl(1'b0);
    endfunction

    function void note_action(action_e act, logic [7:0] data);
      actions_noted++;
      case (act)
        ACT_BEGIN_CMD, ACT_BEGIN_DATA: begin
          set_sda(1'b1);
          set_scl(1'b1);
          set_sda(1'b0);
          set_scl(1'b0);
          shift_byte(dev_addr);
          shift_byte((act == ACT_BEGIN_CMD) ? CTRL_COMMAND : CTRL_DATA);
        end
        ACT_PAYLOAD: shift_byte(data);
        default: begin
          set_sda(1'b0);
          set_scl(1'b1);
          set_sda(1'b1);
        end
      endcase
      expected_words[expected_words.size() - 1].last = 1'b1;
    endfunction

    function void check_word(logic scl, logic sda, logic last);
      pin_word_t w;
      words_checked++;
      if (expected_words.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected word scl=%b sda=%b last=%b", $time, scl, sda, last);
        return;
      end
      w = expected_words.pop_front();
      if (scl !== w.scl) begin
        mismatches++;
        $display("%0t: scl expected %b actual %b", $time, w.scl, scl);
      end
      if (sda !== w.sda) begin
        mismatches++;
        $display("%0t: sda expected %b actual %b", $time, w.sda, sda);
      end
      if (last !== w.last) begin
        mismatches++;
        $display("%0t: last expected %b actual %b", $time, w.last, last);
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic [7:0]  cfg_data;

  i2cws_in_if  in_bus();
  i2cws_out_if out_bus();

  pin_word_board board = new();

  // Idle controls: percentages change every stretch; the tail of the run is kept quiet.
  int unsigned stall_pct;
  int unsigned gap_pct;
  bit          quiet_tail;
  int unsigned hold_left;
  int unsigned cycle_count;
  int unsigned cfg_writes;

  display_i2c_write_serializer u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_bus),
    .out_o      (out_bus),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Hold the run to the cycle limit.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("display_i2c_write_serializer: mismatch");
    $finish;
  end

  // Pick new idle rates every stretch; a zero rate gives a run with no idling.
  function automatic int unsigned pick_rate();
    case ($urandom_range(2))
      0: return 0;
      1: return 10;
      default: return 35;
    endcase
  endfunction

  initial begin
    stall_pct = 0;
    gap_pct   = 0;
    forever begin
      stall_pct = pick_rate();
      gap_pct   = pick_rate();
      repeat (160) @(posedge clk_i);
    end
  end

  // Drive out ready: stall in bursts of random length, never in the quiet tail.
  initial begin
    out_bus.ready <= 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(99) < stall_pct) begin
        hold_left = $urandom_range(14, 1) - 1;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // Note every accepted action word and check every accepted pin word at the edge.
  always @(posedge clk_i) begin
    if (in_bus.valid && in_bus.ready)
      board.note_action(action_e'(in_bus.action), in_bus.payload);
    if (out_bus.valid && out_bus.ready)
      board.check_word(out_bus.scl, out_bus.sda, out_bus.last);
  end

  // Present one action word, maybe after a gap, and hold it until it is taken.
  // Keep valid high into the next word when no gap follows.
  task automatic send_action(action_e act, logic [7:0] data);
    int unsigned gap;
    if (!quiet_tail && $urandom_range(99) < gap_pct) begin
      gap = $urandom_range(14, 1);
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.valid   <= 1'b1;
    in_bus.action  <= act;
    in_bus.payload <= data;
    do @(posedge clk_i); while (!(in_bus.valid && in_bus.ready));
  endtask

  // Drop valid, let the last accepted word be noted, wait for every predicted word,
  // then let the sequencer settle.
  task automatic drain();
    in_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (board.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write the device address while the block is idle.
  task automatic write_address(logic [7:0] addr);
    cfg_we   <= 1'b1;
    cfg_data <= addr;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    board.set_address(addr);
    cfg_writes++;
  endtask

  // Mostly well-formed frames (begin, one to six bytes, stop) with random content;
  // mix in stray actions so out-of-order framing shows up too.
  task automatic send_frames(int unsigned count);
    int unsigned sent;
    int unsigned nbytes;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(99) < 15) begin
        send_action(action_e'($urandom_range(3)), 8'($urandom_range(255)));
        sent++;
      end else begin
        send_action($urandom_range(1) ? ACT_BEGIN_DATA : ACT_BEGIN_CMD,
                    8'($urandom_range(255)));
        nbytes = $urandom_range(6, 1);
        repeat (nbytes) send_action(ACT_PAYLOAD, 8'($urandom_range(255)));
        send_action(ACT_STOP, 8'($urandom_range(255)));
        sent += nbytes + 2;
      end
    end
  endtask

  initial begin
    quiet_tail     = 1'b0;
    cfg_writes     = 0;
    rst_ni         <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_data       <= 8'h00;
    in_bus.valid   <= 1'b0;
    in_bus.action  <= ACT_BEGIN_CMD;
    in_bus.payload <= 8'h00;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part on the reset address: out-of-order framing first
    // (stop and payload with no begin), then data bytes at the extremes,
    // a doubled stop, a doubled begin, and begin/stop with junk in the payload.
    send_action(ACT_STOP, 8'hFF);
    send_action(ACT_PAYLOAD, 8'h00);
    send_action(ACT_BEGIN_CMD, 8'hFF);
    send_action(ACT_PAYLOAD, 8'hFF);
    send_action(ACT_PAYLOAD, 8'h80);
    send_action(ACT_PAYLOAD, 8'h01);
    send_action(ACT_STOP, 8'h00);
    send_action(ACT_STOP, 8'h5A);
    send_action(ACT_BEGIN_DATA, 8'h00);
    send_action(ACT_BEGIN_DATA, 8'hA5);
    send_action(ACT_PAYLOAD, 8'h55);
    send_action(ACT_PAYLOAD, 8'hAA);
    send_action(ACT_STOP, 8'h00);
    drain();

    // Address extremes.
    write_address(8'h00);
    send_action(ACT_BEGIN_CMD, 8'h00);
    send_action(ACT_PAYLOAD, 8'h7E);
    send_action(ACT_STOP, 8'h00);
    drain();
    write_address(8'hFF);
    send_action(ACT_BEGIN_DATA, 8'h00);
    send_action(ACT_PAYLOAD, 8'h81);
    send_action(ACT_STOP, 8'h00);
    drain();

    // Random part, a new address for each phase.
    write_address(8'($urandom_range(255)));
    send_frames(RANDOM_ITEMS / 4);
    drain();
    write_address(8'h01);
    send_frames(RANDOM_ITEMS / 4);
    drain();
    write_address(8'hFE);
    send_frames(RANDOM_ITEMS / 4);
    drain();

    // Last phase with no idling on either side.
    write_address(8'($urandom_range(255)));
    quiet_tail = 1'b1;
    send_frames(RANDOM_ITEMS / 4);
    drain();

    $display("Covered %0d actions and %0d pin words across %0d address writes,",
             board.actions_noted, board.words_checked, cfg_writes);
    $display("including framing out of order and idle bursts on both channels.");
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("display_i2c_write_serializer: match");
    end else begin
      $display("display_i2c_write_serializer: mismatch");
    end
    $finish;
  end

endmodule
